@@ sv/rps_pkg.sv @@
`timescale 1ns / 1ps
package rps_pkg;
	localparam int RING_WIDTH = 2048;
	localparam int MAX_SELECT = 16;
	localparam int ADDR_W = $clog2(RING_WIDTH);
	localparam int CNT_W = $clog2(RING_WIDTH) + 1;
	localparam int COL_W = 11;
	localparam int SEL_W = $clog2(MAX_SELECT + 1);
	localparam int CFG_W = 54;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_BOX_MIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_BOX_MAX = 3'd1;
	localparam logic [IDX_W-1:0] REG_NORMAL  = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET  = 3'd3;
	localparam logic [IDX_W-1:0] REG_RADIUS  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SELECT  = 3'd5;

	typedef struct packed {
		logic [53:0] box_min;
		logic [53:0] box_max;
		logic [47:0] normal;
		logic [17:0] offset;
		logic [16:0] radius;
		logic [4:0]  select_count;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [COL_W-1:0]  data;
	} wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SEL_W-1:0] sel;
	} cmd_t;
endpackage

@@ sv/rps_front.sv @@
`timescale 1ns / 1ps
module rps_front (
	input  logic            clk,
	input  logic            arst_n,
	input  rps_pkg::cfg_t   cfg,
	input  logic            accept,
	input  logic [17:0]     point_x,
	input  logic [17:0]     point_y,
	input  logic [17:0]     point_z,
	input  logic            point_invalid,
	input  logic [10:0]     column,
	input  logic            last_in_ring,
	output rps_pkg::wr_t    wr,
	output logic            cmd_push,
	output rps_pkg::cmd_t   cmd
);
	import rps_pkg::*;

	logic                   v_s1, last_s1, inbox_s1;
	logic [COL_W-1:0]       col_s1;
	logic signed [33:0]     px_s1, py_s1, pz_s1;
	logic [CNT_W-1:0]       count_q;
	logic                   inbox;
	logic signed [36:0]     sum, mag, d14;
	logic                   match, wr_en;
	logic [SEL_W-1:0]       sel_clamp;

	assign inbox = !point_invalid
		&& $signed(point_x) > $signed(cfg.box_min[17:0])
		&& $signed(point_x) < $signed(cfg.box_max[17:0])
		&& $signed(point_y) > $signed(cfg.box_min[35:18])
		&& $signed(point_y) < $signed(cfg.box_max[35:18])
		&& $signed(point_z) > $signed(cfg.box_min[53:36])
		&& $signed(point_z) < $signed(cfg.box_max[53:36]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= last_in_ring;
			inbox_s1 <= inbox;
			col_s1   <= column;
			px_s1    <= $signed(point_x) * $signed(cfg.normal[15:0]);
			py_s1    <= $signed(point_y) * $signed(cfg.normal[31:16]);
			pz_s1    <= $signed(point_z) * $signed(cfg.normal[47:32]);
		end
	end

	always_comb begin
		d14 = 37'($signed(cfg.offset)) <<< 14;
		sum = 37'(px_s1) + 37'(py_s1) + 37'(pz_s1) + d14;
		mag = sum[36] ? -sum : sum;
		match = v_s1 && inbox_s1 && (mag <= $signed({6'd0, cfg.radius, 14'd0}));
		wr_en = match && (count_q < CNT_W'(RING_WIDTH));
	end

	assign sel_clamp = (cfg.select_count > 5'(MAX_SELECT)) ? SEL_W'(MAX_SELECT)
		: SEL_W'(cfg.select_count);

	assign wr.we   = wr_en;
	assign wr.addr = count_q[ADDR_W-1:0];
	assign wr.data = col_s1;

	assign cmd_push = v_s1 && last_s1;
	assign cmd.cnt  = count_q + CNT_W'(wr_en);
	assign cmd.sel  = sel_clamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_push) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
		end
	end
endmodule

@@ sv/rps_cmd_fifo.sv @@
`timescale 1ns / 1ps
module rps_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rps_pkg::cmd_t din,
	input  logic          pop,
	output logic          nonempty,
	output logic          full,
	output rps_pkg::cmd_t dout
);
	import rps_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign nonempty = cnt_q != 2'd0;
	assign full     = cnt_q == 2'd2;
	assign dout     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ sv/rps_back.sv @@
`timescale 1ns / 1ps
module rps_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rps_pkg::wr_t      wr,
	input  logic              cmd_valid,
	input  rps_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	output logic              done,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [10:0]       picked_column,
	output logic              last_pick
);
	import rps_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;
	localparam int IT_W = $clog2(CNT_W + 1);

	logic [COL_W-1:0]  mem [RING_WIDTH];
	logic [COL_W-1:0]  rdata_q;
	logic [2:0]        state_q;
	logic [CNT_W-1:0]  quo_q, acc_q, step_q;
	logic [SEL_W:0]    rem_q, div_q;
	logic [SEL_W+1:0]  trial;
	logic [SEL_W-1:0]  sel_q, k_q;
	logic [IT_W-1:0]   it_q;
	logic              go;
	logic [CNT_W-1:0]  step_n;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (state_q == ST_RD) begin
			rdata_q <= mem[ADDR_W'(acc_q - 1'b1)];
		end
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign go = (cmd.sel != '0) && ({1'b0, cmd.cnt} >= ((CNT_W+1)'(cmd.sel) << 1));
	assign trial = {rem_q, quo_q[CNT_W-1]};
	assign step_n = (quo_q == '0) ? CNT_W'(1) : quo_q;

	assign out_valid     = state_q == ST_OUT;
	assign picked_column = rdata_q;
	assign last_pick     = k_q == sel_q;
	assign done = (cmd_pop && !go) || (out_valid && out_ready && last_pick);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && go) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (it_q == IT_W'(CNT_W)) state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) state_q <= last_pick ? ST_IDLE : ST_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q <= cmd.cnt;
				rem_q <= '0;
				div_q <= (SEL_W+1)'(cmd.sel) + 1'b1;
				sel_q <= cmd.sel;
				it_q  <= '0;
				k_q   <= SEL_W'(1);
			end
			ST_DIV: begin
				if (it_q == IT_W'(CNT_W)) begin
					step_q <= step_n;
					acc_q  <= step_n;
				end else begin
					it_q <= it_q + 1'b1;
					if (trial >= {1'b0, div_q}) begin
						rem_q <= (SEL_W+1)'(trial - {1'b0, div_q});
						quo_q <= {quo_q[CNT_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[SEL_W:0];
						quo_q <= {quo_q[CNT_W-2:0], 1'b0};
					end
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					k_q   <= k_q + 1'b1;
					acc_q <= acc_q + step_q;
				end
			end
			default: ;
		endcase
	end
endmodule

@@ sv/ring_plane_point_selection_core.sv @@
`timescale 1ns / 1ps
// Ring plane point selection.
// Points of one ring stream in on in_valid/in_ready, one transaction a cycle
// while in_ready is high, each carrying coordinates, an invalid flag, the
// column and last_in_ring. Matching columns are stored in a RING_WIDTH-entry
// buffer. After the last point of a ring the back end divides the match
// count by select_count+1, select_count clamped to MAX_SELECT (one quotient
// bit a cycle), and then reads the picked columns one at a time on
// out_valid/out_ready, with last_pick on the final one of the ring.
// in_ready drops after a last point is taken and rises again once that
// ring's picks have all been delivered (or right away when none qualify),
// since the buffer is reused by the next ring.
// When the receiver stalls, the current pick holds on the outputs.
// Reset clears the match count, the command queue and all state machines;
// the buffer needs no clearing; select_count resets to 1, the rest to 0.
// The user must write config (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
module ring_plane_point_selection_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [53:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [17:0] point_x,
	input  logic [17:0] point_y,
	input  logic [17:0] point_z,
	input  logic        point_invalid,
	input  logic [10:0] column,
	input  logic        last_in_ring,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] picked_column,
	output logic        last_pick
);
	import rps_pkg::*;

	cfg_t cfg_q;
	logic hold_q, accept, cmd_push, cmd_valid, cmd_pop, fifo_full, done;
	wr_t  wr;
	cmd_t cmd_in, cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{box_min: '0, box_max: '0, normal: '0, offset: '0, radius: '0,
				select_count: 5'd1};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_MIN: cfg_q.box_min      <= cfg_data;
				REG_BOX_MAX: cfg_q.box_max      <= cfg_data;
				REG_NORMAL:  cfg_q.normal       <= cfg_data[47:0];
				REG_OFFSET:  cfg_q.offset       <= cfg_data[17:0];
				REG_RADIUS:  cfg_q.radius       <= cfg_data[16:0];
				REG_SELECT:  cfg_q.select_count <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !hold_q;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (accept && last_in_ring) begin
			hold_q <= 1'b1;
		end else if (done) begin
			hold_q <= 1'b0;
		end
	end

	rps_front u_front (
		.clk, .arst_n, .cfg(cfg_q), .accept,
		.point_x, .point_y, .point_z, .point_invalid, .column, .last_in_ring,
		.wr, .cmd_push, .cmd(cmd_in)
	);

	rps_cmd_fifo u_fifo (
		.clk, .arst_n, .push(cmd_push), .din(cmd_in), .pop(cmd_pop),
		.nonempty(cmd_valid), .full(fifo_full), .dout(cmd_out)
	);

	rps_back u_back (
		.clk, .arst_n, .wr, .cmd_valid, .cmd(cmd_out), .cmd_pop, .done,
		.out_valid, .out_ready, .picked_column, .last_pick
	);

	a_out_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hold_q) else $error("pick outside a ring end");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !fifo_full) else $error("command queue overflow");
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> in_ready) else $error("input not released after ring end");
endmodule

@@ verif/ring_plane_point_selection_core_tb.sv @@
`timescale 1ns / 1ps
module ring_plane_point_selection_core_tb;
	import rps_pkg::*;

	typedef struct {
		logic [10:0] col;
		logic        lastp;
	} pick_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [53:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [17:0] point_x;
	logic [17:0] point_y;
	logic [17:0] point_z;
	logic        point_invalid;
	logic [10:0] column;
	logic        last_in_ring;
	logic        out_valid;
	logic        out_ready;
	logic [10:0] picked_column;
	logic        last_pick;

	ring_plane_point_selection_core u_top (.*);

	// predictor copy of registers and ring state
	logic [53:0] m_box_min, m_box_max;
	logic [47:0] m_normal;
	logic [17:0] m_offset;
	logic [16:0] m_radius;
	logic [4:0]  m_select;
	logic [10:0] m_cols [RING_WIDTH];
	int          m_count;

	pick_t picks_q[$];
	int    errors;
	int    n_items;
	int    n_picks;
	int    n_rings;
	int    stall_mode;   // 0 random, 1 none, 2 long hold-off
	int    hold_cycles;
	int    sink_gap;
	bit    sender_idle;
	int    col_ctr;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic bit hits_plane(logic [17:0] x, logic [17:0] y, logic [17:0] z);
		longint px, py, pz, proj, lim;
		px = longint'($signed(x));
		py = longint'($signed(y));
		pz = longint'($signed(z));
		if (!(px > $signed(m_box_min[17:0]) && px < $signed(m_box_max[17:0]) &&
		      py > $signed(m_box_min[35:18]) && py < $signed(m_box_max[35:18]) &&
		      pz > $signed(m_box_min[53:36]) && pz < $signed(m_box_max[53:36])))
			return 0;
		proj = longint'($signed(m_normal[15:0])) * px + longint'($signed(m_normal[31:16])) * py
			+ longint'($signed(m_normal[47:32])) * pz + longint'($signed(m_offset)) * 16384;
		if (proj < 0)
			proj = -proj;
		lim = longint'(m_radius) * 16384;
		return proj <= lim;
	endfunction

	function automatic void predict_point(logic [17:0] x, logic [17:0] y, logic [17:0] z,
		logic inv, logic [10:0] c, logic lst);
		int sel, stride;
		pick_t p;
		if (!inv && hits_plane(x, y, z) && m_count < RING_WIDTH) begin
			m_cols[m_count] = c;
			m_count++;
		end
		if (!lst)
			return;
		n_rings++;
		sel = (m_select > MAX_SELECT) ? MAX_SELECT : m_select;
		if (sel > 0 && m_count >= 2 * sel) begin
			stride = m_count / (sel + 1);
			if (stride < 1)
				stride = 1;
			for (int k = 1; k <= sel; k++) begin
				p.col = m_cols[stride * k - 1];
				p.lastp = (k == sel);
				picks_q.insert(picks_q.size(), p);
			end
		end
		m_count = 0;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [53:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_BOX_MIN: m_box_min = val;
			REG_BOX_MAX: m_box_max = val;
			REG_NORMAL:  m_normal = val[47:0];
			REG_OFFSET:  m_offset = val[17:0];
			REG_RADIUS:  m_radius = val[16:0];
			REG_SELECT:  m_select = val[4:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (picks_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// sends one point; gaps only when random idling is on
	task automatic send_point(input logic [17:0] x, input logic [17:0] y, input logic [17:0] z,
		input logic inv, input logic lst);
		if (stall_mode == 0 && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		point_invalid <= inv;
		column <= col_ctr[10:0];
		last_in_ring <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_point(x, y, z, inv, col_ctr[10:0], lst);
		n_items++;
		col_ctr = lst ? 0 : col_ctr + 1;
		@(negedge clk);
	endtask

	// box of +-1000 mm around the origin, plane z = 0 at given radius
	task automatic set_plane(input int rad, input int sel);
		write_reg(REG_BOX_MIN, {18'(-1000), 18'(-1000), 18'(-1000)});
		write_reg(REG_BOX_MAX, {18'(1000), 18'(1000), 18'(1000)});
		write_reg(REG_NORMAL, {16'sd16384, 16'sd0, 16'sd0});
		write_reg(REG_OFFSET, 18'd0);
		write_reg(REG_RADIUS, 54'(rad));
		write_reg(REG_SELECT, 54'(sel));
	endtask

	// mostly points near the plane, inside the box
	task automatic send_ring(input int len, input int hit_pct);
		logic [17:0] x, y, z;
		for (int i = 0; i < len; i++) begin
			x = 18'($urandom_range(0, 1998) - 999);
			y = 18'($urandom_range(0, 1998) - 999);
			if ($urandom_range(0, 99) < hit_pct)
				z = 18'($urandom_range(0, 100) - 50);
			else
				z = 18'($urandom);
			send_point(x, y, z, $urandom_range(0, 9) == 0, i == len - 1);
		end
	endtask

	task automatic test_directed();
		set_plane(50, 3);
		// box edges are exclusive
		send_point(18'(-1000), 0, 0, 0, 0);
		send_point(18'(1000), 0, 0, 0, 0);
		send_point(0, 18'(999), 0, 0, 0);
		send_point(0, 0, 18'(50), 0, 0);
		send_point(0, 0, 18'(-50), 0, 0);
		send_point(0, 0, 18'(51), 0, 0);
		send_point(0, 0, 0, 1, 0);
		send_point(18'h20000, 18'h1ffff, 0, 0, 0);
		for (int i = 0; i < 5; i++)
			send_point(18'(i), 18'(-i), 18'(i), 0, 0);
		send_point(0, 0, 0, 0, 1);   // last point itself matches
		wait_drained();
		// too few matches
		send_point(0, 0, 0, 0, 0);
		send_point(0, 0, 0, 0, 1);
		wait_drained();
		write_reg(REG_SELECT, 54'd0);   // zero select count
		for (int i = 0; i < 4; i++)
			send_point(0, 0, 0, 0, i == 3);
		wait_drained();
		write_reg(REG_SELECT, 54'd31);  // clamps to the max
		send_ring(40, 100);
		wait_drained();
	endtask

	task automatic test_extreme_regs();
		// full-range box, tilted normal, extreme offset and radius
		write_reg(REG_BOX_MIN, {3{18'h20000}});
		write_reg(REG_BOX_MAX, {3{18'h1ffff}});
		write_reg(REG_NORMAL, {16'h8000, 16'h7fff, 16'h2d41});
		write_reg(REG_OFFSET, 18'h20000);
		write_reg(REG_RADIUS, 54'h1ffff);
		write_reg(REG_SELECT, 54'd1);
		for (int i = 0; i < 30; i++)
			send_point(18'($urandom), 18'($urandom), 18'($urandom), $urandom_range(0, 1),
				i == 29);
		wait_drained();
		write_reg(REG_OFFSET, 18'h1ffff);
		for (int i = 0; i < 20; i++)
			send_point(18'($urandom), 18'($urandom), 18'($urandom), 0, i == 19);
		wait_drained();
	endtask

	task automatic test_random_rings();
		while (n_items < 280) begin
			set_plane($urandom_range(10, 120), $urandom_range(1, 16));
			repeat (3)
				send_ring($urandom_range(8, 40), $urandom_range(50, 95));
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		set_plane(60, 16);
		stall_mode = 2;
		hold_cycles = 300;
		send_ring(40, 100);
		send_ring(36, 100);   // stalls behind the held picks
		while (hold_cycles > 0)
			@(posedge clk);
		stall_mode = 0;
		wait_drained();
		sender_idle = 1;
		repeat ($urandom_range(20, 60)) @(posedge clk);
		sender_idle = 0;
		stall_mode = 1;       // tail runs without idling
		send_ring(40, 90);
		send_ring(34, 90);
	endtask

	// result sink: random idle bursts, a long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
			sink_gap = 0;
		end else if (stall_mode == 2 && hold_cycles > 0) begin
			out_ready <= 0;
			hold_cycles--;
		end else if (stall_mode == 0) begin
			if (sink_gap > 0) begin
				out_ready <= 0;
				sink_gap--;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				sink_gap = $urandom_range(1, 6) - 1;
			end else
				out_ready <= 1;
		end else
			out_ready <= 1;
	end

	always @(posedge clk) begin
		pick_t w;
		if (arst_n && out_valid && out_ready) begin
			n_picks++;
			if (picks_q.size() == 0)
				report("unexpected transaction", picked_column, -1);
			else begin
				w = picks_q.pop_front();
				if (picked_column !== w.col)
					report("picked_column", picked_column, w.col);
				if (last_pick !== w.lastp)
					report("last_pick", last_pick, w.lastp);
			end
		end
	end

	initial begin
		errors = 0; n_items = 0; n_picks = 0; n_rings = 0; col_ctr = 0;
		stall_mode = 0; hold_cycles = 0; sender_idle = 0;
		arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; point_x = 0; point_y = 0; point_z = 0;
		point_invalid = 0; column = 0; last_in_ring = 0;
		m_box_min = 0; m_box_max = 0; m_normal = 0; m_offset = 0;
		m_radius = 0; m_select = 1; m_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_extreme_regs();
		test_random_rings();
		test_backpressure();
		in_valid <= 0;
		while (picks_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d points in %0d rings, %0d picks checked", n_items, n_rings,
			n_picks);
		$display("box/plane edges, clamped and zero select, long output hold-off");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/rps_pkg.sv
sv/rps_front.sv
sv/rps_cmd_fifo.sv
sv/rps_back.sv
sv/ring_plane_point_selection_core.sv
verif/ring_plane_point_selection_core_tb.sv
